FILE: src/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants shared by the buddy page allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int COUNT_W = 13;
    localparam int BLK_W   = 12;
    localparam int ORDER_W = 4;
    localparam int ORD_W   = 5;    // internal order width, covers up to order 31

    localparam logic [ORDER_W-1:0] TOP_RESET = 4'd12;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        LOP_TEST,
        LOP_PUSH,
        LOP_PULL
    } t_lop;

    typedef struct packed {
        logic             valid;
        t_lop             op;
        logic [ORD_W-1:0] ord;
    } t_lcmd;

    typedef struct packed {
        logic done;
        logic free;
    } t_lrsp;

    typedef enum logic [1:0] {
        L_CLEAR,
        L_IDLE,
        L_RD,
        L_LINK
    } t_lst;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SEARCH,
        C_SPL_CHK,
        C_SPL_PULL,
        C_SPL_HI,
        C_SPL_LO,
        C_TAKE,
        C_FTEST,
        C_FPUSH,
        C_MCHK,
        C_MTEST,
        C_MPULL_BUD,
        C_MPULL_OWN,
        C_MPUSH,
        C_DONE
    } t_cst;

    // order of a page count: ceil(log2(n)), 0 for n of 0 or 1
    function automatic logic [ORDER_W-1:0] order_of(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] m;
        logic [ORDER_W-1:0] o;
        m = n - COUNT_W'(1);
        o = '0;
        if (n > COUNT_W'(1)) begin
            for (int i = 0; i < COUNT_W; i++) begin
                if (m[i]) o = ORDER_W'(i + 1);
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: src/bpa_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_mem
// Node memories: free bit, next link and prev link, one shared read port
// with registered data and a write port per array.
// ----------------------------------------------------------------------------
module bpa_mem #(
    parameter int AW = 13,
    parameter int DW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic               o_rd_free,
    output logic [DW-1:0]      o_rd_next,
    output logic [DW-1:0]      o_rd_prev,
    input  wire logic          i_we_f,
    input  wire logic [AW-1:0] i_wa_f,
    input  wire logic          i_wd_f,
    input  wire logic          i_we_n,
    input  wire logic [AW-1:0] i_wa_n,
    input  wire logic [DW-1:0] i_wd_n,
    input  wire logic          i_we_p,
    input  wire logic [AW-1:0] i_wa_p,
    input  wire logic [DW-1:0] i_wd_p
);

    localparam int DEPTH = (1 << AW) - 1;

    logic          mem_f [DEPTH];
    logic [DW-1:0] mem_n [DEPTH];
    logic [DW-1:0] mem_p [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_f) mem_f[i_wa_f] <= i_wd_f;
        if (i_we_n) mem_n[i_wa_n] <= i_wd_n;
        if (i_we_p) mem_p[i_wa_p] <= i_wd_p;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_free <= mem_f[i_rd_addr];
            o_rd_next <= mem_n[i_rd_addr];
            o_rd_prev <= mem_p[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/bpa_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_list
// Free list engine: list heads, push, pull and free-bit test on the node
// memories, plus the clearing pass of the free bits after reset.
// ----------------------------------------------------------------------------
module bpa_list import bpa_pkg::*; #(
    parameter int N = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_lcmd            i_cmd,
    input  wire logic [N-1:0]     i_blk,
    output t_lrsp                 o_rsp,
    output logic                  o_ready,
    input  wire logic [ORD_W-1:0] i_head_ord,
    output logic                  o_head_vld,
    output logic [N-1:0]          o_head_blk
);

    localparam int AW    = N + 1;
    localparam int DEPTH = (1 << AW) - 1;
    localparam int HI_W  = $clog2(N + 1);

    t_lst             r_state, n_state;
    t_lop             r_op, n_op;
    logic [N-1:0]     r_blk, n_blk;
    logic [ORD_W-1:0] r_ord, n_ord;
    logic [AW-1:0]    r_pos, n_pos;
    logic [N-1:0]     r_hb, n_hb;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_head_v [N+1];
    logic [N-1:0]     r_head_b [N+1];

    logic             rd_en, rd_free;
    logic [AW-1:0]    rd_addr;
    logic [N:0]       rd_next, rd_prev;
    logic             we_f, wd_f, we_n, we_p;
    logic [AW-1:0]    wa_f, wa_n, wa_p;
    logic [N:0]       wd_n, wd_p;
    logic             hw_en, hw_v;
    logic [N-1:0]     hw_b;
    logic [HI_W-1:0]  hidx;
    logic             hd_v;
    logic [N-1:0]     hd_b;

    // orders laid out one after another, order 0 first
    function automatic logic [AW-1:0] pos(input logic [N-1:0] b, input logic [ORD_W-1:0] o);
        logic [AW:0] base;
        base = ((AW+1)'(1) << AW) - ((AW+1)'(1) << (AW - int'(o)));
        return AW'(base + (AW+1)'(b >> o));
    endfunction

    bpa_mem #(.AW(AW), .DW(N + 1)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_free (rd_free),
        .o_rd_next (rd_next),
        .o_rd_prev (rd_prev),
        .i_we_f    (we_f),
        .i_wa_f    (wa_f),
        .i_wd_f    (wd_f),
        .i_we_n    (we_n),
        .i_wa_n    (wa_n),
        .i_wd_n    (wd_n),
        .i_we_p    (we_p),
        .i_wa_p    (wa_p),
        .i_wd_p    (wd_p)
    );

    // one head read port, shared with the sequencer while idle
    assign hidx       = (r_state == L_IDLE) ? i_head_ord[HI_W-1:0] : r_ord[HI_W-1:0];
    assign hd_v       = r_head_v[hidx];
    assign hd_b       = r_head_b[hidx];
    assign o_head_vld = hd_v;
    assign o_head_blk = hd_b;
    assign o_ready    = (r_state == L_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_CLEAR;
            r_clr   <= '0;
            for (int i = 0; i <= N; i++) r_head_v[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (hw_en) r_head_v[hidx] <= hw_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_blk <= n_blk;
        r_ord <= n_ord;
        r_pos <= n_pos;
        r_hb  <= n_hb;
        if (hw_en) r_head_b[hidx] <= hw_b;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_blk   = r_blk;
        n_ord   = r_ord;
        n_pos   = r_pos;
        n_hb    = r_hb;
        n_clr   = r_clr;
        rd_en   = 1'b0;
        rd_addr = pos(i_blk, i_cmd.ord);
        we_f    = 1'b0;
        wa_f    = r_pos;
        wd_f    = 1'b0;
        we_n    = 1'b0;
        wa_n    = r_pos;
        wd_n    = '0;
        we_p    = 1'b0;
        wa_p    = r_pos;
        wd_p    = '0;
        hw_en   = 1'b0;
        hw_v    = 1'b0;
        hw_b    = r_blk;
        o_rsp   = '0;
        unique case (r_state)
            L_CLEAR: begin
                we_f  = 1'b1;
                wa_f  = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) n_state = L_IDLE;
            end
            L_IDLE: begin
                if (i_cmd.valid) begin
                    rd_en   = 1'b1;
                    n_op    = i_cmd.op;
                    n_blk   = i_blk;
                    n_ord   = i_cmd.ord;
                    n_pos   = rd_addr;
                    n_state = L_RD;
                end
            end
            L_RD: begin
                n_state    = L_IDLE;
                o_rsp.free = rd_free;
                unique case (r_op)
                    LOP_TEST: o_rsp.done = 1'b1;
                    LOP_PUSH: begin
                        if (rd_free) begin
                            o_rsp.done = 1'b1;
                        end else begin
                            we_f  = 1'b1;
                            wd_f  = 1'b1;
                            we_n  = 1'b1;
                            wd_n  = {hd_v, hd_b};
                            we_p  = 1'b1;
                            wd_p  = {1'b1, {N{1'b0}}};
                            hw_en = 1'b1;
                            hw_v  = 1'b1;
                            hw_b  = r_blk;
                            n_hb  = hd_b;
                            if (hd_v) n_state = L_LINK;
                            else o_rsp.done = 1'b1;
                        end
                    end
                    LOP_PULL: begin
                        o_rsp.done = 1'b1;
                        if (rd_free) begin
                            we_f = 1'b1;
                            if (rd_prev[N]) begin
                                hw_en = 1'b1;
                                hw_v  = rd_next[N];
                                hw_b  = rd_next[N-1:0];
                            end else begin
                                we_n = 1'b1;
                                wa_n = pos(rd_prev[N-1:0], r_ord);
                                wd_n = rd_next;
                            end
                            if (rd_next[N]) begin
                                we_p = 1'b1;
                                wa_p = pos(rd_next[N-1:0], r_ord);
                                wd_p = rd_prev;
                            end
                        end
                    end
                    default: o_rsp.done = 1'b1;
                endcase
            end
            L_LINK: begin
                // old head now points back at the new one
                we_p       = 1'b1;
                wa_p       = pos(r_hb, r_ord);
                wd_p       = {1'b0, r_blk};
                o_rsp.done = 1'b1;
                n_state    = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/bpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: free list search, split, free and buddy merge, issuing
// one list command at a time.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; #(
    parameter int N = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_idle,
    input  wire logic               i_kind,
    input  wire logic [COUNT_W-1:0] i_page_count,
    input  wire logic [BLK_W-1:0]   i_block_index,
    input  wire logic [ORDER_W-1:0] i_top,
    output t_lcmd                   o_cmd,
    output logic [N-1:0]            o_blk,
    input  wire t_lrsp              i_rsp,
    output logic [ORD_W-1:0]        o_head_ord,
    input  wire logic               i_head_vld,
    input  wire logic [N-1:0]       i_head_blk,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic [BLK_W-1:0]        o_result_block,
    output logic [ORDER_W-1:0]      o_result_order
);

    t_cst               r_state, n_state;
    logic               r_pend, n_pend;
    logic [ORDER_W-1:0] r_want, n_want;
    logic [ORD_W-1:0]   r_top, n_top;
    logic [ORD_W-1:0]   r_o, n_o;
    logic [N-1:0]       r_b, n_b;
    logic               r_ok, n_ok;
    logic [N-1:0]       r_res, n_res;

    logic [ORDER_W-1:0] want_in;
    logic [ORD_W-1:0]   top_in, want_w, r_want_w;
    logic [N-1:0]       blk_in, aligned, bit_o;

    assign want_in  = order_of(i_page_count);
    assign want_w   = ORD_W'(want_in);
    assign r_want_w = ORD_W'(r_want);
    assign top_in   = (ORD_W'(i_top) > ORD_W'(N)) ? ORD_W'(N) : ORD_W'(i_top);
    assign blk_in   = N'(i_block_index);
    assign aligned  = blk_in & ~((N'(1) << want_in) - N'(1));
    assign bit_o    = N'(1) << r_o;

    assign o_idle         = (r_state == C_IDLE);
    assign o_valid        = (r_state == C_DONE);
    assign o_ok           = r_ok;
    assign o_result_block = BLK_W'(r_res);
    assign o_result_order = r_want;
    assign o_head_ord     = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        r_top  <= n_top;
        r_o    <= n_o;
        r_b    <= n_b;
        r_ok   <= n_ok;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_want    = r_want;
        n_top     = r_top;
        n_o       = r_o;
        n_b       = r_b;
        n_ok      = r_ok;
        n_res     = r_res;
        o_cmd     = '0;
        o_cmd.ord = r_o;
        o_blk     = r_b;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_want = want_in;
                    n_top  = top_in;
                    n_ok   = 1'b0;
                    n_o    = want_w;
                    if (i_kind == KIND_ALLOC) begin
                        n_res   = '0;
                        n_state = (want_w > top_in) ? C_DONE : C_SEARCH;
                    end else if (want_w > top_in) begin
                        n_res   = blk_in;
                        n_state = C_DONE;
                    end else begin
                        n_res   = aligned;
                        n_b     = aligned;
                        n_state = C_FTEST;
                    end
                end
            end
            C_SEARCH: begin
                if (i_head_vld) n_state = C_SPL_CHK;
                else if (r_o == r_top) n_state = C_DONE;
                else n_o = r_o + ORD_W'(1);
            end
            C_SPL_CHK: n_state = (r_o > r_want_w) ? C_SPL_PULL : C_TAKE;
            C_SPL_PULL, C_TAKE, C_FTEST, C_FPUSH, C_MTEST,
            C_MPULL_BUD, C_MPULL_OWN, C_MPUSH, C_SPL_HI, C_SPL_LO: begin
                o_cmd.valid = !r_pend;
                case (r_state)
                    C_SPL_PULL, C_TAKE: begin
                        o_cmd.op = LOP_PULL;
                        o_blk    = i_head_blk;
                    end
                    C_SPL_HI: begin
                        o_cmd.op  = LOP_PUSH;
                        o_cmd.ord = r_o - ORD_W'(1);
                        o_blk     = r_b + (N'(1) << (r_o - ORD_W'(1)));
                    end
                    C_SPL_LO: begin
                        o_cmd.op  = LOP_PUSH;
                        o_cmd.ord = r_o - ORD_W'(1);
                    end
                    C_FTEST: begin
                        o_cmd.op  = LOP_TEST;
                        o_cmd.ord = r_want_w;
                    end
                    C_FPUSH: begin
                        o_cmd.op  = LOP_PUSH;
                        o_cmd.ord = r_want_w;
                    end
                    C_MTEST: begin
                        o_cmd.op = LOP_TEST;
                        o_blk    = r_b ^ bit_o;
                    end
                    C_MPULL_BUD: begin
                        o_cmd.op = LOP_PULL;
                        o_blk    = r_b ^ bit_o;
                    end
                    C_MPULL_OWN: o_cmd.op = LOP_PULL;
                    default: begin
                        o_cmd.op  = LOP_PUSH;
                        o_cmd.ord = r_o + ORD_W'(1);
                        o_blk     = r_b & ~bit_o;
                    end
                endcase
                if (!r_pend) begin
                    n_pend = 1'b1;
                    if (r_state == C_SPL_PULL) n_b = i_head_blk;
                    if (r_state == C_TAKE) n_res = i_head_blk;
                end else if (i_rsp.done) begin
                    n_pend = 1'b0;
                    case (r_state)
                        C_SPL_PULL:  n_state = C_SPL_HI;
                        C_SPL_HI:    n_state = C_SPL_LO;
                        C_SPL_LO: begin
                            n_o     = r_o - ORD_W'(1);
                            n_state = C_SPL_CHK;
                        end
                        C_TAKE: begin
                            n_ok    = 1'b1;
                            n_state = C_DONE;
                        end
                        C_FTEST:     n_state = i_rsp.free ? C_DONE : C_FPUSH;
                        C_FPUSH: begin
                            n_ok    = 1'b1;
                            n_o     = r_want_w;
                            n_state = C_MCHK;
                        end
                        C_MTEST:     n_state = i_rsp.free ? C_MPULL_BUD : C_DONE;
                        C_MPULL_BUD: n_state = C_MPULL_OWN;
                        C_MPULL_OWN: n_state = C_MPUSH;
                        default: begin
                            n_b     = r_b & ~bit_o;
                            n_o     = r_o + ORD_W'(1);
                            n_state = C_MCHK;
                        end
                    endcase
                end
            end
            C_MCHK: n_state = (r_o < r_top) ? C_MTEST : C_DONE;
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/buddy_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator over 2^MAX_ORDER_BITS pages, with per-order free lists.
// ----------------------------------------------------------------------------
// after reset the free bits are swept clear, all 2^(MAX_ORDER_BITS+1)-1 node entries
// (8191 at the default), with busy high; config writes are taken throughout.
// a request walks the free lists one order at a time, then splits or merges level by
// level; every list operation goes through the single read port of the node
// memories, and a push onto a non-empty list adds a link write to the old head. the
// result shows for one cycle on o_valid and cannot be held off.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int MAX_ORDER_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic [COUNT_W-1:0] i_page_count,
    input  wire logic [BLK_W-1:0]   i_block_index,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic [BLK_W-1:0]        o_result_block,
    output logic [ORDER_W-1:0]      o_result_order,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [ORDER_W-1:0] i_cfg_data
);

    localparam int N = MAX_ORDER_BITS;

    logic [ORDER_W-1:0] r_top_order;
    logic               ctrl_idle, list_ready, head_vld;
    t_lcmd              cmd;
    t_lrsp              rsp;
    logic [N-1:0]       cmd_blk, head_blk;
    logic [ORD_W-1:0]   head_ord;

    assign o_cfg_ready = 1'b1;
    assign busy        = !(ctrl_idle && list_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_order <= TOP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_top_order <= i_cfg_data;
        end
    end

    bpa_ctrl #(.N(N)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start && !busy),
        .o_idle         (ctrl_idle),
        .i_kind         (i_kind),
        .i_page_count   (i_page_count),
        .i_block_index  (i_block_index),
        .i_top          (r_top_order),
        .o_cmd          (cmd),
        .o_blk          (cmd_blk),
        .i_rsp          (rsp),
        .o_head_ord     (head_ord),
        .i_head_vld     (head_vld),
        .i_head_blk     (head_blk),
        .o_valid        (o_valid),
        .o_ok           (o_ok),
        .o_result_block (o_result_block),
        .o_result_order (o_result_order)
    );

    bpa_list #(.N(N)) u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_blk      (cmd_blk),
        .o_rsp      (rsp),
        .o_ready    (list_ready),
        .i_head_ord (head_ord),
        .o_head_vld (head_vld),
        .o_head_blk (head_blk)
    );

endmodule
`default_nettype wire

FILE: src/bpa_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_chk
// Port-level checks of the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_chk import bpa_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic               o_ok,
    input wire logic [ORDER_W-1:0] o_result_order
);

    // reset starts the clearing sweep
    a_busy_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_no_res_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result during reset");

    // an accepted request makes busy high in the very next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_single_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy ##1 !o_valid))
        else $error("result repeated or shown while idle");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_result_order <= ORDER_W'(13)))
        else $error("result order out of range");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_ok           (o_ok),
    .o_result_order (o_result_order)
);
`default_nettype wire
